/* rtl/atb_pkg.sv */
// Shared widths and controller/datapath interface types for the alias table builder.
package atb_pkg;

   localparam int DEPTH = 64;
   localparam int IDX_W = 6;
   localparam int CNT_W = 7;
   localparam int WGT_W = 32;
   localparam int TOT_W = 38;
   localparam int SCL_W = 40;
   localparam int PRB_W = 33;
   localparam int REM_W = 39;
   localparam int DCN_W = 6;

   typedef struct packed {
      logic load;
      logic build_clr;
      logic div_start;
      logic div_step;
      logic mul;
      logic fill_wr;
      logic idx_inc;
      logic idx_clr;
      logic pair_lat;
      logic sel_above;
      logic below_lat;
      logic upd;
      logic out_load;
      logic out_zero;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic count_zero;
      logic div_last;
      logic fill_last;
      logic stacks_done;
      logic rsp_taken;
      logic out_last;
   } sts_type;

endpackage

/* rtl/atb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module atb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/atb_ctrl.sv */
// Sequencer for loading, per-entry division, the stack pairing loop and emission.
module atb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tlast,
   output logic             req_tready,
   input  atb_pkg::sts_type sts,
   output atb_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_BRD, ST_DIVINIT, ST_DIV, ST_MUL, ST_FILL,
      ST_LCHK, ST_LLAT, ST_LRDB, ST_LRDA, ST_LUPD, ST_ERD, ST_ELD, ST_EWAIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      req_tready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (sts.count_zero) begin
               cmd.out_zero = 1'b1;
               state_in = ST_EWAIT;
            end else begin
               cmd.build_clr = 1'b1;
               state_in = ST_BRD;
            end
         end
         ST_BRD: state_in = ST_DIVINIT;
         ST_DIVINIT: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            if (sts.fill_last) begin
               cmd.idx_clr = 1'b1;
               state_in = ST_LCHK;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = ST_BRD;
            end
         end
         // Stack tops are read every cycle, so the check cycle also issues the top reads that LLAT latches.
         ST_LCHK: state_in = sts.stacks_done ? ST_ERD : ST_LLAT;
         ST_LLAT: begin
            cmd.pair_lat = 1'b1;
            state_in = ST_LRDB;
         end
         ST_LRDB: state_in = ST_LRDA;
         ST_LRDA: begin
            cmd.below_lat = 1'b1;
            cmd.sel_above = 1'b1;
            state_in = ST_LUPD;
         end
         ST_LUPD: begin
            cmd.upd = 1'b1;
            state_in = ST_LCHK;
         end
         ST_ERD: state_in = ST_ELD;
         ST_ELD: begin
            cmd.out_load = 1'b1;
            state_in = ST_EWAIT;
         end
         ST_EWAIT: begin
            if (sts.rsp_taken) begin
               if (sts.out_last) begin
                  cmd.finish = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in = ST_ERD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/atb_dp.sv */
// Datapath: weight and table memories, stacks, bit-serial divider and output register.
module atb_dp #(
   parameter int MAX_LIGHTS = 64,
   parameter int FRAC_BITS  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  atb_pkg::cmd_type cmd,
   output atb_pkg::sts_type sts,
   input  logic             has_light,
   input  logic [31:0]      weight_value,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic [5:0]       out_index,
   output logic [32:0]      out_pdf,
   output logic [32:0]      out_prob,
   output logic [5:0]       out_alias,
   output logic             out_ovf,
   output logic             out_last
);

   localparam logic [atb_pkg::SCL_W-1:0] ONE = atb_pkg::SCL_W'(1) << FRAC_BITS;
   localparam logic [atb_pkg::DCN_W-1:0] DIV_STEPS = atb_pkg::DCN_W'(FRAC_BITS + 1);
   localparam logic [atb_pkg::CNT_W-1:0] MAX_CNT = atb_pkg::CNT_W'(MAX_LIGHTS);

   logic [atb_pkg::CNT_W-1:0] count_ff, count_in, idx_ff, idx_in;
   logic [atb_pkg::CNT_W-1:0] stop_ff, stop_in, ltop_ff, ltop_in;
   logic [atb_pkg::TOT_W-1:0] total_ff, total_in;
   logic                      ovf_ff, ovf_in;
   logic [atb_pkg::REM_W-1:0] rem_ff, rem_in;
   logic [atb_pkg::TOT_W-1:0] dvs_ff, dvs_in;
   logic [atb_pkg::PRB_W-1:0] quo_ff, quo_in;
   logic [atb_pkg::DCN_W-1:0] dcnt_ff, dcnt_in;
   logic [atb_pkg::SCL_W-1:0] scl_ff, scl_in, sb_ff, sb_in;
   logic [atb_pkg::IDX_W-1:0] below_ff, below_in, above_ff, above_in;
   logic                      valid_ff, valid_in;
   logic [5:0]                oidx_ff, oidx_in, oalias_ff, oalias_in;
   logic [32:0]               opdf_ff, opdf_in, oprob_ff, oprob_in;
   logic                      oovf_ff, oovf_in, olast_ff, olast_in;

   logic [atb_pkg::WGT_W-1:0] w_rd;
   logic [atb_pkg::SCL_W-1:0] scl_rd, scl_wdata;
   logic [atb_pkg::PRB_W-1:0] pdf_rd, prob_rd, prob_wdata;
   logic [atb_pkg::IDX_W-1:0] alias_rd, alias_wdata, small_rd, large_rd;
   logic [atb_pkg::IDX_W-1:0] scl_waddr, tab_waddr, small_waddr, small_wdata;
   logic                      small_we, large_we, load_ok;
   logic                      rem_ge, moved;
   logic [atb_pkg::REM_W-1:0] rem_sub;
   logic [atb_pkg::SCL_W:0]   new_sum;

   assign load_ok = cmd.load && has_light && (count_ff < MAX_CNT);
   assign rem_ge  = rem_ff >= {1'b0, dvs_ff};
   assign rem_sub = rem_ge ? (rem_ff - {1'b0, dvs_ff}) : rem_ff;
   assign new_sum = {1'b0, scl_rd} + {1'b0, sb_ff} - {1'b0, ONE};
   assign moved   = new_sum[atb_pkg::SCL_W-1:0] < ONE;

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      ovf_in   = ovf_ff;
      idx_in   = idx_ff;
      stop_in  = stop_ff;
      ltop_in  = ltop_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      quo_in   = quo_ff;
      dcnt_in  = dcnt_ff;
      scl_in   = scl_ff;
      sb_in    = sb_ff;
      below_in = below_ff;
      above_in = above_ff;
      valid_in = valid_ff;
      oidx_in  = oidx_ff;
      opdf_in  = opdf_ff;
      oprob_in = oprob_ff;
      oalias_in = oalias_ff;
      oovf_in  = oovf_ff;
      olast_in = olast_ff;
      if (load_ok) begin
         count_in = count_ff + 1'b1;
         total_in = total_ff + atb_pkg::TOT_W'(weight_value);
      end else if (cmd.load && has_light) begin
         ovf_in = 1'b1;
      end
      if (cmd.build_clr) begin
         idx_in  = '0;
         stop_in = '0;
         ltop_in = '0;
      end
      // A zero total gives each light 1/count, computed by the same divider.
      if (cmd.div_start) begin
         quo_in  = '0;
         dcnt_in = DIV_STEPS;
         if (total_ff != '0) begin
            rem_in = atb_pkg::REM_W'(w_rd);
            dvs_in = total_ff;
         end else begin
            rem_in = atb_pkg::REM_W'(1);
            dvs_in = atb_pkg::TOT_W'(count_ff);
         end
      end
      if (cmd.div_step) begin
         quo_in  = {quo_ff[atb_pkg::PRB_W-2:0], rem_ge};
         rem_in  = {rem_sub[atb_pkg::REM_W-2:0], 1'b0};
         dcnt_in = dcnt_ff - 1'b1;
      end
      if (cmd.mul) begin
         scl_in = atb_pkg::SCL_W'(quo_ff) * atb_pkg::SCL_W'(count_ff);
      end
      if (cmd.fill_wr) begin
         if (scl_ff < ONE) begin
            stop_in = stop_ff + 1'b1;
         end else begin
            ltop_in = ltop_ff + 1'b1;
         end
      end
      if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end
      if (cmd.pair_lat) begin
         below_in = small_rd;
         above_in = large_rd;
      end
      if (cmd.below_lat) begin
         sb_in = scl_rd;
      end
      // The moved index reuses the slot that the popped one leaves on the small stack.
      if (cmd.upd) begin
         if (moved) begin
            ltop_in = ltop_ff - 1'b1;
         end else begin
            stop_in = stop_ff - 1'b1;
         end
      end
      if (cmd.out_load) begin
         valid_in  = 1'b1;
         oidx_in   = idx_ff[atb_pkg::IDX_W-1:0];
         opdf_in   = pdf_rd;
         oprob_in  = prob_rd;
         oalias_in = alias_rd;
         oovf_in   = ovf_ff;
         olast_in  = (idx_ff + 1'b1) == count_ff;
      end
      if (cmd.out_zero) begin
         valid_in  = 1'b1;
         oidx_in   = '0;
         opdf_in   = '0;
         oprob_in  = '0;
         oalias_in = '0;
         oovf_in   = ovf_ff;
         olast_in  = 1'b1;
      end
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (cmd.finish) begin
         count_in = '0;
         total_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
         idx_ff   <= '0;
         stop_ff  <= '0;
         ltop_ff  <= '0;
         dcnt_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
         idx_ff   <= idx_in;
         stop_ff  <= stop_in;
         ltop_ff  <= ltop_in;
         dcnt_ff  <= dcnt_in;
         valid_ff <= valid_in;
      end
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      scl_ff    <= scl_in;
      sb_ff     <= sb_in;
      below_ff  <= below_in;
      above_ff  <= above_in;
      oidx_ff   <= oidx_in;
      opdf_ff   <= opdf_in;
      oprob_ff  <= oprob_in;
      oalias_ff <= oalias_in;
      oovf_ff   <= oovf_in;
      olast_ff  <= olast_in;
   end

   assign scl_waddr   = cmd.upd ? above_ff : idx_ff[atb_pkg::IDX_W-1:0];
   assign scl_wdata   = cmd.upd ? new_sum[atb_pkg::SCL_W-1:0] : scl_ff;
   assign tab_waddr   = cmd.upd ? below_ff : idx_ff[atb_pkg::IDX_W-1:0];
   assign prob_wdata  = cmd.upd ? sb_ff[atb_pkg::PRB_W-1:0] : ONE[atb_pkg::PRB_W-1:0];
   assign alias_wdata = cmd.upd ? above_ff : idx_ff[atb_pkg::IDX_W-1:0];
   assign small_we    = (cmd.fill_wr && (scl_ff < ONE)) || (cmd.upd && moved);
   assign large_we    = cmd.fill_wr && !(scl_ff < ONE);
   assign small_waddr = cmd.upd ? (stop_ff[atb_pkg::IDX_W-1:0] - 1'b1)
                                : stop_ff[atb_pkg::IDX_W-1:0];
   assign small_wdata = cmd.upd ? above_ff : idx_ff[atb_pkg::IDX_W-1:0];

   atb_ram #(.WIDTH(atb_pkg::WGT_W), .DEPTH(atb_pkg::DEPTH)) u_weight (
      .clock(clock), .wr_en(load_ok), .wr_addr(count_ff[atb_pkg::IDX_W-1:0]),
      .wr_data(weight_value), .rd_addr(idx_ff[atb_pkg::IDX_W-1:0]), .rd_data(w_rd)
   );

   atb_ram #(.WIDTH(atb_pkg::SCL_W), .DEPTH(atb_pkg::DEPTH)) u_scaled (
      .clock(clock), .wr_en(cmd.fill_wr || cmd.upd), .wr_addr(scl_waddr),
      .wr_data(scl_wdata), .rd_addr(cmd.sel_above ? above_ff : below_ff), .rd_data(scl_rd)
   );

   atb_ram #(.WIDTH(atb_pkg::PRB_W), .DEPTH(atb_pkg::DEPTH)) u_pdf (
      .clock(clock), .wr_en(cmd.fill_wr), .wr_addr(idx_ff[atb_pkg::IDX_W-1:0]),
      .wr_data(quo_ff), .rd_addr(idx_ff[atb_pkg::IDX_W-1:0]), .rd_data(pdf_rd)
   );

   atb_ram #(.WIDTH(atb_pkg::PRB_W), .DEPTH(atb_pkg::DEPTH)) u_prob (
      .clock(clock), .wr_en(cmd.fill_wr || cmd.upd), .wr_addr(tab_waddr),
      .wr_data(prob_wdata), .rd_addr(idx_ff[atb_pkg::IDX_W-1:0]), .rd_data(prob_rd)
   );

   atb_ram #(.WIDTH(atb_pkg::IDX_W), .DEPTH(atb_pkg::DEPTH)) u_alias (
      .clock(clock), .wr_en(cmd.fill_wr || cmd.upd), .wr_addr(tab_waddr),
      .wr_data(alias_wdata), .rd_addr(idx_ff[atb_pkg::IDX_W-1:0]), .rd_data(alias_rd)
   );

   atb_ram #(.WIDTH(atb_pkg::IDX_W), .DEPTH(atb_pkg::DEPTH)) u_small (
      .clock(clock), .wr_en(small_we), .wr_addr(small_waddr), .wr_data(small_wdata),
      .rd_addr(stop_ff[atb_pkg::IDX_W-1:0] - 1'b1), .rd_data(small_rd)
   );

   atb_ram #(.WIDTH(atb_pkg::IDX_W), .DEPTH(atb_pkg::DEPTH)) u_large (
      .clock(clock), .wr_en(large_we), .wr_addr(ltop_ff[atb_pkg::IDX_W-1:0]),
      .wr_data(idx_ff[atb_pkg::IDX_W-1:0]),
      .rd_addr(ltop_ff[atb_pkg::IDX_W-1:0] - 1'b1), .rd_data(large_rd)
   );

   assign sts.count_zero  = (count_ff == '0);
   assign sts.div_last    = (dcnt_ff == atb_pkg::DCN_W'(1));
   assign sts.fill_last   = ((idx_ff + 1'b1) == count_ff);
   assign sts.stacks_done = (stop_ff == '0) || (ltop_ff == '0);
   assign sts.rsp_taken   = valid_ff && rsp_tready;
   assign sts.out_last    = olast_ff;

   assign rsp_tvalid = valid_ff;
   assign out_index  = oidx_ff;
   assign out_pdf    = opdf_ff;
   assign out_prob   = oprob_ff;
   assign out_alias  = oalias_ff;
   assign out_ovf    = oovf_ff;
   assign out_last   = olast_ff;

endmodule

/* rtl/alias_table_builder.sv */
// Top level of the alias table builder: controller plus datapath.
//
//  Channel | Direction | Beat contents
//  req     | in        | tdata: weight_value[31:0]; tuser: has_light; tlast: end_of_set
//  rsp     | out       | tdata: index, pdf, keep prob, alias; tuser: overflowed; tlast: last
//
// The block is ready for a weight beat in every cycle while it collects.
// The end-of-set beat starts the build: each entry is read, divided by the one-bit-per-cycle
// divider, scaled and written, then each pairing step does its memory reads and updates.
// Each result beat is read and held through any stall on rsp_tready; no beat is taken meanwhile.
// Reset is synchronous and clears the count, sum, flag, stack tops and controller.
module alias_table_builder #(
   parameter int MAX_LIGHTS = 64,
   parameter int FRAC_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] weight_value
   input  logic        req_tuser,   // [0] has_light
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [5:0] index, [38:6] pdf, [71:39] keep, [77:72] alias
   output logic        rsp_tuser,   // [0] overflowed
   output logic        rsp_tlast
);

   atb_pkg::cmd_type cmd;
   atb_pkg::sts_type sts;
   logic [5:0]       out_index, out_alias;
   logic [32:0]      out_pdf, out_prob;

   atb_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tlast(req_tlast),
      .req_tready(req_tready), .sts(sts), .cmd(cmd)
   );

   atb_dp #(.MAX_LIGHTS(MAX_LIGHTS), .FRAC_BITS(FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .has_light(req_tuser), .weight_value(req_tdata),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid),
      .out_index(out_index), .out_pdf(out_pdf), .out_prob(out_prob),
      .out_alias(out_alias), .out_ovf(rsp_tuser), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, out_alias, out_prob, out_pdf, out_index};

endmodule
